FILE: design/tast_pkg.sv
package tast_pkg;

    localparam int INTERVAL_WIDTH = 24;
    localparam int RND_W          = 32;
    localparam int CNT_W          = 8;
    localparam int CFG_W          = 8;
    localparam int DBL_W          = 5;
    localparam int MAX_DBL        = 16;
    localparam int MIN_LEN        = 2;
    localparam int WIDE_W         = INTERVAL_WIDTH + MAX_DBL;
    localparam int STEP_W         = $clog2(RND_W);

    localparam logic [INTERVAL_WIDTH-1:0] IMASK     = '1;
    localparam logic [CNT_W-1:0]          COUNT_MAX = 8'hFF;

    // configuration register indexes
    localparam logic [1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_MAX_DOUBLE   = 2'd1;
    localparam logic [1:0] CFG_REDUNDANCY   = 2'd2;

    localparam logic [CFG_W-1:0] RST_MIN_INTERVAL = 8'd2;
    localparam logic [DBL_W-1:0] RST_MAX_DOUBLE   = 5'd4;
    localparam logic [CFG_W-1:0] RST_REDUNDANCY   = 8'd1;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_HEARD = 2'd2,
        KIND_STOP  = 2'd3
    } t_kind;

    typedef enum logic {
        DIV_SPAN = 1'b0,
        DIV_HALF = 1'b1
    } t_div_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_LEN,
        ST_FIRE_GO,
        ST_DIV_FIRE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     exec;
        logic     div_start;
        t_div_sel div_sel;
        logic     load_len;
        logic     load_fire;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic is_start;
        logic is_end;
        logic rem_done;
    } t_sts;

endpackage

FILE: design/tast_rem.sv
module tast_rem
    import tast_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [RND_W-1:0]          i_dividend,
    input  logic [INTERVAL_WIDTH-1:0] i_divisor,
    output logic                      o_done,
    output logic [INTERVAL_WIDTH-1:0] o_rem
);

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [STEP_W-1:0]         r_cnt, n_cnt;
    logic [RND_W-1:0]          r_dvd, n_dvd;
    logic [INTERVAL_WIDTH-1:0] r_dsr, n_dsr;
    logic [INTERVAL_WIDTH-1:0] r_rem, n_rem;
    logic [INTERVAL_WIDTH:0]   trial;

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        trial  = {r_rem, r_dvd[RND_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dsr}) begin
                trial = trial - {1'b0, r_dsr};
            end
            n_rem = trial[INTERVAL_WIDTH-1:0];
            n_dvd = {r_dvd[RND_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == STEP_W'(RND_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`ifndef SYNTH
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dsr))
        else $error("remainder not below divisor");
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("remainder unit still busy at done");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("remainder unit did not start");
`endif

endmodule

FILE: design/tast_dp.sv
module tast_dp
    import tast_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic [1:0]                i_kind,
    input  logic [RND_W-1:0]          i_random_word,
    input  logic                      i_pa_received,
    input  logic                      i_best_pan_found,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    output logic                      o_send_solicit,
    output logic                      o_suppressed,
    output logic                      o_interval_ended,
    output logic                      o_running,
    output logic [INTERVAL_WIDTH-1:0] o_interval_now,
    output logic [CNT_W-1:0]          o_heard_now
);

    localparam int IW = INTERVAL_WIDTH;

    // configuration
    logic [CFG_W-1:0] r_cfg_min;
    logic [DBL_W-1:0] r_cfg_dbl;
    logic [CFG_W-1:0] r_cfg_k;

    // timer state
    logic [IW-1:0]    r_len, r_pos, r_fire;
    logic [CNT_W-1:0] r_heard, r_attempts;
    logic             r_fired, r_run;

    // request being worked on
    t_kind            r_kind;
    logic [RND_W-1:0] r_rnd;
    logic             r_pa, r_best;
    logic             r_sent, r_supp, r_ended;

    // result register
    logic             r_o_sent, r_o_supp, r_o_ended, r_o_run;
    logic [IW-1:0]    r_o_len;
    logic [CNT_W-1:0] r_o_heard;

    logic [CFG_W-1:0]  eff_min;
    logic [DBL_W-1:0]  eff_dbl;
    logic [WIDE_W-1:0] wide_max;
    logic [IW-1:0]     imax, span, half, divisor, pos_inc, rem;
    logic              fire_hit, under_k, rem_done;

    always_comb begin
        eff_min  = (r_cfg_min < CFG_W'(MIN_LEN)) ? CFG_W'(MIN_LEN) : r_cfg_min;
        eff_dbl  = (r_cfg_dbl > DBL_W'(MAX_DBL)) ? DBL_W'(MAX_DBL) : r_cfg_dbl;
        wide_max = WIDE_W'(eff_min) << eff_dbl;
        imax     = (wide_max > WIDE_W'(IMASK)) ? IMASK : wide_max[IW-1:0];
        span     = imax - IW'(eff_min) + 1'b1;
        half     = (r_len >> 1 == '0) ? IW'(1) : (r_len >> 1);
        divisor  = (i_cmd.div_sel == DIV_HALF) ? half : span;
        pos_inc  = r_pos + 1'b1;
        fire_hit = !r_fired && (pos_inc == r_fire);
        under_k  = (r_heard < r_cfg_k) || (r_cfg_k == '0);
    end

    tast_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rnd),
        .i_divisor  (divisor),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    assign o_sts.is_start = (r_kind == KIND_START);
    assign o_sts.is_end   = (r_kind == KIND_TICK) && r_run && (pos_inc >= r_len);
    assign o_sts.rem_done = rem_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_min  <= RST_MIN_INTERVAL;
            r_cfg_dbl  <= RST_MAX_DOUBLE;
            r_cfg_k    <= RST_REDUNDANCY;
            r_len      <= '0;
            r_pos      <= '0;
            r_fire     <= '0;
            r_heard    <= '0;
            r_attempts <= '0;
            r_fired    <= 1'b0;
            r_run      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_INTERVAL: r_cfg_min <= i_cfg_data;
                    CFG_MAX_DOUBLE:   r_cfg_dbl <= i_cfg_data[DBL_W-1:0];
                    CFG_REDUNDANCY:   r_cfg_k   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                case (r_kind)
                    KIND_START: r_run <= 1'b1;
                    KIND_HEARD: begin
                        if (r_heard != COUNT_MAX) begin
                            r_heard <= r_heard + 1'b1;
                        end
                    end
                    KIND_STOP: begin
                        r_run   <= 1'b0;
                        r_len   <= '0;
                        r_pos   <= '0;
                        r_fire  <= '0;
                        r_fired <= 1'b0;
                    end
                    default: begin
                        if (r_run) begin
                            r_pos <= pos_inc;
                            if (fire_hit) begin
                                r_fired <= 1'b1;
                                // best-PAN suppression does not count as an attempt
                                if (!(under_k && r_pa && r_best && r_attempts != '0)
                                        && r_attempts != COUNT_MAX) begin
                                    r_attempts <= r_attempts + 1'b1;
                                end
                            end
                            if (pos_inc >= r_len) begin
                                r_len <= (r_len <= (imax >> 1)) ? (r_len << 1) : imax;
                            end
                        end
                    end
                endcase
            end
            if (i_cmd.load_len) begin
                r_len <= IW'(eff_min) + rem;
            end
            if (i_cmd.load_fire) begin
                r_fire  <= half + rem;
                r_pos   <= '0;
                r_heard <= '0;
                r_fired <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= t_kind'(i_kind);
            r_rnd   <= i_random_word;
            r_pa    <= i_pa_received;
            r_best  <= i_best_pan_found;
            r_sent  <= 1'b0;
            r_supp  <= 1'b0;
            r_ended <= 1'b0;
        end else if (i_cmd.exec && r_kind == KIND_TICK && r_run) begin
            if (fire_hit) begin
                r_sent <= under_k && !(r_pa && r_best && r_attempts != '0);
                r_supp <= !under_k || (r_pa && r_best && r_attempts != '0);
            end
            r_ended <= (pos_inc >= r_len);
        end
        if (i_cmd.out_load) begin
            r_o_sent  <= r_sent;
            r_o_supp  <= r_supp;
            r_o_ended <= r_ended;
            r_o_run   <= r_run;
            r_o_len   <= r_len;
            r_o_heard <= r_heard;
        end
    end

    assign o_send_solicit   = r_o_sent;
    assign o_suppressed     = r_o_supp;
    assign o_interval_ended = r_o_ended;
    assign o_running        = r_o_run;
    assign o_interval_now   = r_o_len;
    assign o_heard_now      = r_o_heard;

`ifndef SYNTH
    a_fire_in_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_fire |=> (r_fire < r_len))
        else $error("fire point outside interval");
    a_stopped_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run |-> (r_len == '0))
        else $error("interval length set while stopped");
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sent && r_supp))
        else $error("send and suppress both set");
`endif

endmodule

FILE: design/tast_ctrl.sv
module tast_ctrl
    import tast_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_out_stall,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.div_sel = DIV_SPAN;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.is_start) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV_LEN;
                end else if (i_sts.is_end) begin
                    n_state = ST_FIRE_GO;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV_LEN: begin
                if (i_sts.rem_done) begin
                    o_cmd.load_len = 1'b1;
                    n_state        = ST_FIRE_GO;
                end
            end
            ST_FIRE_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_HALF;
                n_state         = ST_DIV_FIRE;
            end
            ST_DIV_FIRE: begin
                o_cmd.div_sel = DIV_HALF;
                if (i_sts.rem_done) begin
                    o_cmd.load_fire = 1'b1;
                    n_state         = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("pending result overwritten");
    a_done_when_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.rem_done |-> (r_state == ST_DIV_LEN || r_state == ST_DIV_FIRE))
        else $error("remainder finished outside a divide state");
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_EXEC))
        else $error("accepted request not executed");
`endif

endmodule

FILE: design/trickle_advert_solicit_timer.sv
// Trickle timer that schedules solicit transmissions.
// Input channel (i_in_valid / o_in_stall): one request per event: a tick,
//   a start, a heard consistent transmission or a stop, with a random word
//   and the PAN status bits. Output channel (o_out_valid / i_out_stall):
//   exactly one result per request, in order.
// Configuration: i_cfg_we writes register i_cfg_idx (0 min interval,
//   1 max doublings, 2 redundancy k) from i_cfg_data; the user must write
//   only while idle, as the block itself does not enforce it.
// Request accepted to result registered: heard, stop and a tick inside
//   an interval execute and load the result; a tick that ends an interval
//   adds one remainder pass, a start two. The next request is taken in
//   the cycle after the result loads.
// One request is in work at a time; the passes run on the shared
//   bit-serial remainder unit, one random bit per cycle over 32 bits.
// Reset (i_rst_n low, synchronous) stops the timer, clears all counters
//   and restores the configuration defaults (2, 4, 1).
// A stalled result stays on the output; the next request is still taken
//   and worked, and then waits until the output register frees up.
module trickle_advert_solicit_timer
    import tast_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_kind,
    input  logic [RND_W-1:0]          i_random_word,
    input  logic                      i_pa_received,
    input  logic                      i_best_pan_found,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_send_solicit,
    output logic                      o_suppressed,
    output logic                      o_interval_ended,
    output logic                      o_running,
    output logic [INTERVAL_WIDTH-1:0] o_interval_now,
    output logic [CNT_W-1:0]          o_heard_now
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: accept, execute, divide passes, hand off the result
    tast_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // timer state, config registers, remainder unit and result register
    tast_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_random_word    (i_random_word),
        .i_pa_received    (i_pa_received),
        .i_best_pan_found (i_best_pan_found),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_send_solicit   (o_send_solicit),
        .o_suppressed     (o_suppressed),
        .o_interval_ended (o_interval_ended),
        .o_running        (o_running),
        .o_interval_now   (o_interval_now),
        .o_heard_now      (o_heard_now)
    );

endmodule

FILE: tb/tb_top.sv
module tb_top;
    import tast_pkg::*;

    // ---------------------------------------------------------------
    // Run limits
    // ---------------------------------------------------------------
    // Slowest request is a start (two remainder passes).
    // Give idle phases a bit more than that before touching registers.
    localparam int DRAIN_CYCLES = 100;
    // Receiver hold-off used by the back-pressure test.
    localparam int HOLD_CYCLES  = 400;
    // Watchdog: cycles with no handshake of any kind. Worst legit case
    // is the hold-off above plus one start plus a long gap on each side.
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 60;
    localparam int PHASES       = 10;
    localparam int FLOOD_ITEMS  = 260;
    localparam int BURST_ITEMS  = 24;

    // One expected result; field order follows the output ports.
    typedef struct packed {
        logic                      send_solicit;
        logic                      suppressed;
        logic                      interval_ended;
        logic                      running;
        logic [INTERVAL_WIDTH-1:0] interval_now;
        logic [CNT_W-1:0]          heard_now;
    } t_result;

    // ---------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ---------------------------------------------------------------
    logic                      i_clk            = 1'b0;
    logic                      i_rst_n          = 1'b0;
    logic                      i_cfg_we         = 1'b0;
    logic [1:0]                i_cfg_idx        = CFG_MIN_INTERVAL;
    logic [CFG_W-1:0]          i_cfg_data       = '0;
    logic                      i_in_valid       = 1'b0;
    logic                      o_in_stall;
    t_kind                     req_kind         = KIND_TICK;
    logic [RND_W-1:0]          i_random_word    = '0;
    logic                      i_pa_received    = 1'b0;
    logic                      i_best_pan_found = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall      = 1'b0;
    logic                      o_send_solicit;
    logic                      o_suppressed;
    logic                      o_interval_ended;
    logic                      o_running;
    logic [INTERVAL_WIDTH-1:0] o_interval_now;
    logic [CNT_W-1:0]          o_heard_now;

    trickle_advert_solicit_timer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (req_kind),
        .i_random_word    (i_random_word),
        .i_pa_received    (i_pa_received),
        .i_best_pan_found (i_best_pan_found),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_send_solicit   (o_send_solicit),
        .o_suppressed     (o_suppressed),
        .o_interval_ended (o_interval_ended),
        .o_running        (o_running),
        .o_interval_now   (o_interval_now),
        .o_heard_now      (o_heard_now)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Shared testbench state
    // ---------------------------------------------------------------
    t_result timer_results_due[$];   // predicted results, oldest first
    int      mismatches   = 0;
    int      items_sent   = 0;
    int      results_seen = 0;
    int      solicits     = 0;
    int      suppressions = 0;
    int      ends_seen    = 0;
    int      reg_writes   = 0;
    logic    no_idle      = 1'b0;    // both sides run flat out
    logic    hold_out_req = 1'b0;    // ask receiver for a long hold-off

    // ---------------------------------------------------------------
    // Timer shadow: registers and state, updated per accepted request
    // ---------------------------------------------------------------
    logic [CFG_W-1:0]          r_min = RST_MIN_INTERVAL;
    logic [DBL_W-1:0]          r_dbl = RST_MAX_DOUBLE;
    logic [CFG_W-1:0]          r_k   = RST_REDUNDANCY;

    logic [INTERVAL_WIDTH-1:0] m_len      = '0;
    logic [INTERVAL_WIDTH-1:0] m_pos      = '0;
    logic [INTERVAL_WIDTH-1:0] m_fire     = '0;
    logic [CNT_W-1:0]          m_heard    = '0;
    logic [CNT_W-1:0]          m_attempts = '0;
    logic                      m_fired    = 1'b0;
    logic                      m_run      = 1'b0;

    // Imin, with anything under 2 treated as 2
    function automatic logic [63:0] floor_len();
        if (r_min < MIN_LEN)
            return 64'(MIN_LEN);
        return 64'(r_min);
    endfunction

    // Imax = Imin << doublings, doublings clamped at 16, value clamped
    // to the interval width
    function automatic logic [63:0] ceiling_len();
        logic [63:0] v;
        int          d;
        d = (r_dbl > MAX_DBL) ? MAX_DBL : int'(r_dbl);
        v = floor_len() << d;
        if (v > 64'(IMASK))
            v = 64'(IMASK);
        return v;
    endfunction

    // New fire point in [I/2, I); also opens a fresh interval
    function automatic void draw_fire_point(logic [RND_W-1:0] rnd);
        logic [63:0] half;
        logic [63:0] f;
        half = 64'(m_len >> 1);
        if (half == 0)
            half = 1;
        f        = half + 64'(rnd) % half;
        m_fire   = f[INTERVAL_WIDTH-1:0];
        m_pos    = '0;
        m_heard  = '0;
        m_fired  = 1'b0;
    endfunction

    function automatic void bump_attempts();
        if (m_attempts != COUNT_MAX)
            m_attempts = m_attempts + 1'b1;
    endfunction

    function automatic t_result trickle_predict(t_kind kind, logic [RND_W-1:0] rnd,
                                                logic pa, logic best);
        t_result     r;
        logic [63:0] mn;
        logic [63:0] mx;
        logic [63:0] span;
        logic [63:0] len;
        r = '0;
        case (kind)
            KIND_START: begin
                // start (or restart) from scratch; one word feeds both draws
                mn    = floor_len();
                mx    = ceiling_len();
                span  = (mx >= mn) ? (mx - mn + 1) : 64'd1;
                len   = mn + 64'(rnd) % span;
                m_len = len[INTERVAL_WIDTH-1:0];
                m_run = 1'b1;
                draw_fire_point(rnd);
            end
            KIND_HEARD: begin
                // counts even while stopped, saturating
                if (m_heard != COUNT_MAX)
                    m_heard = m_heard + 1'b1;
            end
            KIND_STOP: begin
                m_run   = 1'b0;
                m_len   = '0;
                m_pos   = '0;
                m_fire  = '0;
                m_fired = 1'b0;
            end
            default: begin
                if (m_run) begin
                    m_pos = m_pos + 1'b1;
                    if (!m_fired && m_pos == m_fire) begin
                        m_fired = 1'b1;
                        if (m_heard < r_k || r_k == 0) begin
                            // best-PAN check blocks without counting an attempt
                            if (pa && m_attempts != 0 && best) begin
                                r.suppressed = 1'b1;
                            end else begin
                                r.send_solicit = 1'b1;
                                bump_attempts();
                            end
                        end else begin
                            r.suppressed = 1'b1;
                            bump_attempts();
                        end
                    end
                    if (m_pos >= m_len) begin
                        // Imax follows the registers at each doubling
                        mx = ceiling_len();
                        r.interval_ended = 1'b1;
                        if (64'(m_len) <= (mx >> 1))
                            m_len = m_len << 1;
                        else
                            m_len = mx[INTERVAL_WIDTH-1:0];
                        draw_fire_point(rnd);
                    end
                end
            end
        endcase
        r.running      = m_run;
        r.interval_now = m_len;
        r.heard_now    = m_heard;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Idle gap: mostly none or short, now and then a long one
    // ---------------------------------------------------------------
    function automatic int idle_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    // Offers one request, holds it until taken, then records the
    // predicted result. Valid stays high on return so back-to-back
    // requests need no extra cycle.
    task automatic send_event(t_kind kind, logic [RND_W-1:0] rnd, logic pa, logic best);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        req_kind         <= kind;
        i_random_word    <= rnd;
        i_pa_received    <= pa;
        i_best_pan_found <= best;
        do @(posedge i_clk); while (o_in_stall);
        timer_results_due.push_back(trickle_predict(kind, rnd, pa, best));
        items_sent++;
    endtask

    // Mostly a well-formed trickle session: long runs of ticks with
    // some heard events, occasional restart/stop, a little noise.
    task automatic send_random_event();
        t_kind kind;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 78)
            kind = KIND_TICK;
        else if (r < 88)
            kind = KIND_HEARD;
        else if (r < 93)
            kind = KIND_START;
        else if (r < 96)
            kind = KIND_STOP;
        else
            kind = t_kind'($urandom_range(0, 3));
        send_event(kind, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Drop valid, wait out every pending result, then give the block
    // time to go fully idle before any register write.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (timer_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write; only called from an idle block.
    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_INTERVAL: r_min = data;
            CFG_MAX_DOUBLE:   r_dbl = data[DBL_W-1:0];
            CFG_REDUNDANCY:   r_k   = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic write_all_regs(logic [CFG_W-1:0] imin, logic [DBL_W-1:0] dbl,
                                  logic [CFG_W-1:0] k);
        write_reg(CFG_MIN_INTERVAL, imin);
        write_reg(CFG_MAX_DOUBLE, CFG_W'(dbl));
        write_reg(CFG_REDUNDANCY, k);
    endtask

    // ---------------------------------------------------------------
    // Result side: receiver stall pattern
    // ---------------------------------------------------------------
    initial begin : result_stall
        int hold;
        int run;
        @(posedge i_clk);
        forever begin
            if (hold_out_req) begin
                // long hold-off, counted here, so the block backs up
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out_req = 1'b0;
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                hold = idle_gap();
                if (hold > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                run = no_idle ? 1 : $urandom_range(1, 12);
                repeat (run) @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // Result checker: every taken result against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        string   bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_send_solicit, o_suppressed, o_interval_ended, o_running,
                    o_interval_now, o_heard_now};
            if (timer_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with no request pending: %p", $realtime, got);
            end else begin
                want = timer_results_due.pop_front();
                results_seen++;
                bad = "";
                if (got.send_solicit   != want.send_solicit)   bad = {bad, " send_solicit"};
                if (got.suppressed     != want.suppressed)     bad = {bad, " suppressed"};
                if (got.interval_ended != want.interval_ended) bad = {bad, " interval_ended"};
                if (got.running        != want.running)        bad = {bad, " running"};
                if (got.interval_now   != want.interval_now)   bad = {bad, " interval_now"};
                if (got.heard_now      != want.heard_now)      bad = {bad, " heard_now"};
                if (bad != "") begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] result %0d mismatch on%s", $realtime, results_seen, bad);
                        $display("    expected send=%0b supp=%0b end=%0b run=%0b len=%0d heard=%0d",
                                 want.send_solicit, want.suppressed, want.interval_ended,
                                 want.running, want.interval_now, want.heard_now);
                        $display("    actual   send=%0b supp=%0b end=%0b run=%0b len=%0d heard=%0d",
                                 got.send_solicit, got.suppressed, got.interval_ended,
                                 got.running, got.interval_now, got.heard_now);
                    end
                end
                if (want.send_solicit)   solicits++;
                if (want.suppressed)     suppressions++;
                if (want.interval_ended) ends_seen++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: too long without any handshake means a hang
    // ---------------------------------------------------------------
    initial begin : watchdog
        int dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || i_cfg_we)
                dead_cycles = 0;
            else
                dead_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, timer_results_due.size());
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset config (2, 4, 1). Idle events while stopped, then a short
    // interval walked through: send at the fire point, doubling, a
    // suppression by k, then restart while running and stop.
    task automatic test_reset_defaults();
        send_event(KIND_TICK,  '0, 1'b0, 1'b0);     // ignored while stopped
        send_event(KIND_HEARD, '0, 1'b0, 1'b0);     // counts while stopped
        send_event(KIND_STOP,  '0, 1'b0, 1'b0);
        send_event(KIND_START, '0, 1'b0, 1'b0);     // I = Imin, fire at I/2
        send_event(KIND_TICK,  '0, 1'b0, 1'b0);     // fires: sends
        send_event(KIND_TICK,  '1, 1'b0, 1'b0);     // interval ends, doubles
        send_event(KIND_HEARD, '1, 1'b1, 1'b1);
        repeat (4) send_event(KIND_TICK, '1, 1'b1, 1'b1);   // heard >= k
        send_event(KIND_START, '1, 1'b1, 1'b0);     // restart while running
        send_event(KIND_STOP,  '1, 1'b1, 1'b1);
        settle();
    endtask

    // k = 0 never suppresses, whatever was heard.
    task automatic test_never_suppress();
        write_reg(CFG_REDUNDANCY, '0);
        send_event(KIND_START, '0, 1'b0, 1'b0);
        send_event(KIND_HEARD, '0, 1'b0, 1'b0);
        send_event(KIND_HEARD, '0, 1'b0, 1'b0);
        send_event(KIND_TICK,  '0, 1'b0, 1'b0);
        settle();
    endtask

    // PA seen, earlier attempt made, best PAN known: blocked, not counted.
    task automatic test_best_pan_block();
        write_reg(CFG_REDUNDANCY, '1);
        send_event(KIND_START, '0, 1'b1, 1'b1);
        send_event(KIND_TICK,  '0, 1'b1, 1'b1);
        send_event(KIND_TICK,  '0, 1'b1, 1'b0);
        settle();
    endtask

    // Register extremes: Imin below 2, doublings above 16, largest Imin
    // with most doublings, and Imax equal to Imin.
    task automatic test_reg_extremes();
        write_all_regs('0, 5'd31, 8'd1);
        send_event(KIND_START, '1, 1'b0, 1'b1);
        send_event(KIND_TICK,  '1, 1'b0, 1'b1);
        settle();
        write_all_regs('1, 5'd16, 8'd255);
        send_event(KIND_START, '1, 1'b1, 1'b0);
        send_event(KIND_STOP,  '0, 1'b0, 1'b0);
        settle();
        write_all_regs(8'd1, 5'd0, 8'd2);
        send_event(KIND_START, 32'h8000_0001, 1'b0, 1'b0);
        settle();
    endtask

    // Random register settings, mostly small intervals so that fire
    // points and doublings come often. The timer is left running
    // across phases so a new Imax meets an interval already in flight.
    task automatic test_random_phases();
        logic [CFG_W-1:0] imin;
        logic [DBL_W-1:0] dbl;
        logic [CFG_W-1:0] k;
        int               r;
        for (int p = 0; p < PHASES; p++) begin
            r = $urandom_range(0, 99);
            imin = (r < 60) ? CFG_W'($urandom_range(0, 6)) :
                   (r < 85) ? CFG_W'($urandom_range(7, 40)) : CFG_W'($urandom_range(41, 255));
            r = $urandom_range(0, 99);
            dbl = (r < 70) ? DBL_W'($urandom_range(0, 4)) :
                  (r < 90) ? DBL_W'($urandom_range(5, 16)) : DBL_W'($urandom_range(17, 31));
            r = $urandom_range(0, 99);
            k = (r < 30) ? '0 : (r < 80) ? CFG_W'($urandom_range(1, 3)) :
                CFG_W'($urandom_range(4, 255));
            write_all_regs(imin, dbl, k);
            no_idle = (p % 4 == 3);     // some phases with no idling at all
            if ($urandom_range(0, 99) < 80)
                send_event(KIND_START, $urandom, 1'b0, 1'b0);
            repeat (PHASE_ITEMS) send_random_event();
            settle();
            no_idle = 1'b0;
        end
    endtask

    // Receiver holds off while the sender keeps offering requests back
    // to back, so the block fills and stalls its request side.
    task automatic test_back_pressure();
        write_all_regs(8'd2, 5'd1, 8'd1);
        send_event(KIND_START, $urandom, 1'b0, 1'b0);
        hold_out_req = 1'b1;
        no_idle      = 1'b1;
        repeat (BURST_ITEMS) send_random_event();
        no_idle = 1'b0;
        while (hold_out_req) @(posedge i_clk);
        settle();
    endtask

    // Heard events while stopped, enough to saturate the count, then a
    // session whose start clears the count again.
    task automatic test_heard_flood();
        send_event(KIND_STOP, $urandom, 1'b0, 1'b0);
        repeat (FLOOD_ITEMS)
            send_event(KIND_HEARD, $urandom, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        send_event(KIND_START, $urandom, 1'b0, 1'b0);
        repeat (8) send_random_event();
        settle();
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : main_seq
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_never_suppress();
        test_best_pan_block();
        test_reg_extremes();
        test_random_phases();
        test_back_pressure();
        test_heard_flood();
        settle();

        $display("Ran %0d requests over %0d register writes; %0d results checked.",
                 items_sent, reg_writes, results_seen);
        $display("Saw %0d solicits, %0d suppressions, %0d interval ends; %0d mismatches.",
                 solicits, suppressions, ends_seen, mismatches);
        if (mismatches == 0 && timer_results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: trickle_advert_solicit_timer.f
design/tast_pkg.sv
design/tast_rem.sv
design/tast_dp.sv
design/tast_ctrl.sv
design/trickle_advert_solicit_timer.sv
tb/tb_top.sv
